>>> rtl/core/ia_pkg.sv
// ----------------------------------------------------------------------------
// ia_pkg
// shared constants, types and helpers for the integer to ascii converter
// ----------------------------------------------------------------------------
package ia_pkg;

    localparam int VALUE_BITS        = 32;
    localparam int MAX_WIDTH         = 32;
    localparam int IN_BITS           = 32;
    localparam int MIN_WIDTH_W       = 6;
    localparam int REQ_W             = 7;
    localparam int HEX_DEFAULT_WIDTH = 8;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h61;

    // bits of the value that take part in the conversion
    localparam int USE_BITS = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;

    // decimal digits needed for the largest value
    function automatic int dec_digits(input int bits);
        logic [63:0] v;
        int          n;
        begin
            v = (64'd1 << bits) - 64'd1;
            n = 0;
            do
            begin
                v = v / 64'd10;
                n = n + 1;
            end
            while (v != 64'd0);
            return n;
        end
    endfunction

    localparam int NDIG  = dec_digits(USE_BITS);
    localparam int BCD_W = 4 * NDIG;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int ND_W  = $clog2(NDIG + 1);
    localparam int CNT_W = (WID_W > ND_W) ? WID_W : ND_W;
    localparam int BIT_W = $clog2(USE_BITS + 1);

    typedef struct packed {
        logic [BCD_W-1:0] digits;   // most significant digit in the top nibble
        logic [CNT_W-1:0] nd;       // true digit count, at least one
        logic [CNT_W-1:0] width;    // effective minimum width
    } conv_res_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        begin
            if (d > 4'd9)
                return CHAR_A + {4'd0, d} - 8'd10;
            else
                return CHAR_ZERO + {4'd0, d};
        end
    endfunction

endpackage

>>> rtl/core/ia_conv.sv
// ----------------------------------------------------------------------------
// ia_conv
// bit-serial binary to bcd / hex digit converter with leading zero strip
// ----------------------------------------------------------------------------
module ia_conv
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ia_pkg::IN_BITS-1:0] value,
    input  logic                      hex_mode,
    input  logic [ia_pkg::MIN_WIDTH_W-1:0] min_width,
    output logic                      idle,
    output logic                      done,
    input  logic                      take,
    output ia_pkg::conv_res_t         res
);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_SHIFT = 2'd1;
    localparam logic [1:0] C_ALIGN = 2'd2;
    localparam logic [1:0] C_DONE  = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [ia_pkg::USE_BITS-1:0]    val_reg, val_next;
    logic [ia_pkg::BCD_W-1:0]       bcd_reg, bcd_next;
    logic [ia_pkg::BIT_W-1:0]       cnt_reg, cnt_next;
    logic [ia_pkg::CNT_W-1:0]       nd_reg, nd_next;
    logic [ia_pkg::CNT_W-1:0]       width_reg, width_next;
    logic                           hex_reg, hex_next;
    logic [ia_pkg::BCD_W-1:0]       corr;
    logic [ia_pkg::REQ_W-1:0]       req;

    // add-3 correction per digit before each shift, decimal only
    always_comb
    begin
        for (int i = 0; i < ia_pkg::NDIG; i++)
        begin
            if (!hex_reg && bcd_reg[i*4 +: 4] >= 4'd5)
                corr[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                corr[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        req = {1'b0, min_width};
        if (hex_mode && min_width == '0)
            req = ia_pkg::REQ_W'(ia_pkg::HEX_DEFAULT_WIDTH);
        if (req > ia_pkg::REQ_W'(ia_pkg::MAX_WIDTH))
            req = ia_pkg::REQ_W'(ia_pkg::MAX_WIDTH);
    end

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        nd_next    = nd_reg;
        width_next = width_reg;
        hex_next   = hex_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    val_next   = value[ia_pkg::USE_BITS-1:0];
                    bcd_next   = '0;
                    cnt_next   = ia_pkg::BIT_W'(ia_pkg::USE_BITS);
                    hex_next   = hex_mode;
                    width_next = ia_pkg::CNT_W'(req);
                    state_next = C_SHIFT;
                end
            end
            C_SHIFT:
            begin
                bcd_next = {corr[ia_pkg::BCD_W-2:0], val_reg[ia_pkg::USE_BITS-1]};
                val_next = {val_reg[ia_pkg::USE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == ia_pkg::BIT_W'(1))
                begin
                    nd_next    = ia_pkg::CNT_W'(ia_pkg::NDIG);
                    state_next = C_ALIGN;
                end
            end
            C_ALIGN:
            begin
                // strip leading zero digits, keep at least one
                if (bcd_reg[ia_pkg::BCD_W-1 -: 4] == 4'd0 && nd_reg > ia_pkg::CNT_W'(1))
                begin
                    bcd_next = {bcd_reg[ia_pkg::BCD_W-5:0], 4'd0};
                    nd_next  = nd_reg - 1'b1;
                end
                else
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:
            begin
                if (take)
                    state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        bcd_reg   <= bcd_next;
        nd_reg    <= nd_next;
        width_reg <= width_next;
        hex_reg   <= hex_next;
    end

    assign idle       = (state_reg == C_IDLE);
    assign done       = (state_reg == C_DONE);
    assign res.digits = bcd_reg;
    assign res.nd     = nd_reg;
    assign res.width  = width_reg;

endmodule

>>> rtl/core/ia_emit.sv
// ----------------------------------------------------------------------------
// ia_emit
// character sequencer: zero padding, then, unless out_ready stalls, one digit per cycle from the top
// ----------------------------------------------------------------------------
module ia_emit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ia_pkg::conv_res_t res,
    output logic              idle,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        character,
    output logic              last_char
);

    logic                     run_reg, run_next;
    logic [ia_pkg::BCD_W-1:0] dig_reg, dig_next;
    logic [ia_pkg::CNT_W-1:0] pad_reg, pad_next;
    logic [ia_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic                     ovalid_reg, ovalid_next;
    logic [7:0]               char_reg, char_next;
    logic                     last_reg, last_next;
    logic                     step;

    assign step = run_reg && (!ovalid_reg || out_ready);

    always_comb
    begin
        run_next    = run_reg;
        dig_next    = dig_reg;
        pad_next    = pad_reg;
        rem_next    = rem_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg && !out_ready;
        if (load)
        begin
            run_next = 1'b1;
            dig_next = res.digits;
            rem_next = res.nd;
            pad_next = (res.width > res.nd) ? res.width - res.nd : '0;
        end
        else if (step)
        begin
            ovalid_next = 1'b1;
            if (pad_reg != '0)
            begin
                char_next = ia_pkg::CHAR_ZERO;
                last_next = 1'b0;
                pad_next  = pad_reg - 1'b1;
            end
            else
            begin
                char_next = ia_pkg::digit_char(dig_reg[ia_pkg::BCD_W-1 -: 4]);
                dig_next  = {dig_reg[ia_pkg::BCD_W-5:0], 4'd0};
                rem_next  = rem_reg - 1'b1;
                last_next = (rem_reg == ia_pkg::CNT_W'(1));
                if (rem_reg == ia_pkg::CNT_W'(1))
                    run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            run_reg    <= run_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        pad_reg  <= pad_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign idle      = !run_reg;
    assign out_valid = ovalid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

endmodule

>>> rtl/core/int_to_ascii_padded.sv
// ----------------------------------------------------------------------------
// int_to_ascii_padded
// unsigned integer to zero padded decimal or lower-case hex ascii text
// ----------------------------------------------------------------------------
//  channel | signals                             | transaction
//  --------+-------------------------------------+------------------------------
//  in      | in_valid in_ready value hex_mode    | one number to convert
//          | min_width                           |
//  out     | out_valid out_ready character       | one character, msd first
//          | last_char                           |
//
//  conversion shifts one value bit per cycle, then strips leading zero
//  digits (up to 9) until it finds the first digit; the done state hands off
//  to the emitter, which loads the digits and registers the first character
//  in its output register; the emitter then sends one character per cycle
//  while out_ready is high, max(digits, width) of them; in_ready returns
//  after the hand-off, and a busy emitter holds the converter in done
//  out_ready low simply holds the output register; rst_n clears all control
// ----------------------------------------------------------------------------
module int_to_ascii_padded
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ia_pkg::IN_BITS-1:0]     value,
    input  logic                           hex_mode,
    input  logic [ia_pkg::MIN_WIDTH_W-1:0] min_width,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     character,
    output logic                           last_char
);

    logic              conv_idle;
    logic              conv_done;
    logic              emit_idle;
    logic              handoff;
    ia_pkg::conv_res_t conv_res;

    assign in_ready = conv_idle;
    assign handoff  = conv_done && emit_idle;

    ia_conv u_conv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .value     (value),
        .hex_mode  (hex_mode),
        .min_width (min_width),
        .idle      (conv_idle),
        .done      (conv_done),
        .take      (handoff),
        .res       (conv_res)
    );

    ia_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (handoff),
        .res       (conv_res),
        .idle      (emit_idle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last_char (last_char)
    );

endmodule

>>> rtl/core/ia_checker.sv
// ----------------------------------------------------------------------------
// ia_checker
// port level checks for the integer to ascii converter
// ----------------------------------------------------------------------------
module ia_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] character,
    input  logic       last_char
);

    // converter is busy after taking a number
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after an input transaction");

    // characters of one number come back to back while the sink is ready
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_char |=> out_valid)
        else $error("gap inside a number");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character >= 8'h30 && character <= 8'h39) ||
                      (character >= 8'h61 && character <= 8'h66))
        else $error("character outside digit set");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last_char))
        else $error("output changed while stalled");

endmodule

bind int_to_ascii_padded ia_checker u_ia_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last_char (last_char)
);
